// File: hw/rtl/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared types and constants for the switch deglitch and lockout block.
// ----------------------------------------------------------------------------
package sdl_pkg;

  // Switch count and field widths
  localparam int NUM_SWITCHES = 9;
  localparam int TYPE_W       = 2;
  localparam int TYPES_W      = TYPE_W * NUM_SWITCHES;
  localparam int TICKS_W      = 15;
  localparam int CNT_W        = 16;
  localparam int CMD_W        = 2;
  localparam int CFG_DATA_W   = TYPES_W;
  localparam int CFG_IDX_W    = 2;

  // Input tdata layout, padded to whole bytes
  localparam int IN_BITS   = CMD_W + NUM_SWITCHES;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, padded to whole bytes
  localparam int OUT_BITS   = 2 * NUM_SWITCHES;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_RESYNC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // Switch type codes
  localparam logic [TYPE_W-1:0] TYPE_OFF = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_NO  = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_NC  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TYPES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGLITCH_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS  = 2'd2;

  // Register reset values
  localparam logic [TYPES_W-1:0] SWITCH_TYPES_RST   = 18'd87381;
  localparam logic [TICKS_W-1:0] DEGLITCH_TICKS_RST = 15'd30;
  localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RST  = 15'd250;

  // Per-switch debounce phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEGLITCH = 2'd1,
    PH_LOCKOUT  = 2'd2
  } phase_t;

  // Control shared by all lanes
  typedef struct packed {
    logic               step;
    logic [CMD_W-1:0]   cmd;
    logic [TICKS_W-1:0] deglitch_ticks;
    logic [TICKS_W-1:0] lockout_ticks;
  } sdl_ctrl_t;

  // Status returned by one lane
  typedef struct packed {
    logic active;
    logic fired;
  } sdl_stat_t;

endpackage

// File: hw/rtl/sdl_lane.sv
// ----------------------------------------------------------------------------
// sdl_lane
// Deglitch and lockout state of one switch, updated once per step.
// ----------------------------------------------------------------------------
module sdl_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  sdl_pkg::sdl_ctrl_t         ctrl,
  input  logic [sdl_pkg::TYPE_W-1:0] sw_type,
  input  logic                       pin,
  output sdl_pkg::sdl_stat_t         stat
);

  sdl_pkg::phase_t                 phase;
  sdl_pkg::phase_t                 phase_next;
  logic [sdl_pkg::CNT_W-1:0]       cnt;
  logic [sdl_pkg::CNT_W-1:0]       cnt_next;
  logic                            active;
  logic                            active_next;
  logic                            en;
  logic                            lvl;
  logic                            busy;
  logic [sdl_pkg::CNT_W-1:0]       cnt_inc;
  logic [sdl_pkg::CNT_W-1:0]       cnt_start;
  logic                            hit_lockout;
  logic                            hit_zero;

  // Decode type and qualified level
  assign en  = (sw_type == sdl_pkg::TYPE_NO) || (sw_type == sdl_pkg::TYPE_NC);
  assign lvl = (sw_type == sdl_pkg::TYPE_NO) ? ~pin : pin;
  assign busy = (phase != sdl_pkg::PH_IDLE);

  // Counter arithmetic
  assign cnt_inc     = cnt + sdl_pkg::CNT_W'(1);
  assign cnt_start   = sdl_pkg::CNT_W'(0) - {1'b0, ctrl.deglitch_ticks};
  assign hit_lockout = (cnt_inc == {1'b0, ctrl.lockout_ticks});
  assign hit_zero    = (cnt_inc == '0);

  // Next state
  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    active_next = active;
    if (ctrl.step) begin
      unique case (ctrl.cmd)
        sdl_pkg::CMD_RESYNC: begin
          active_next = en & lvl;
          phase_next  = sdl_pkg::PH_IDLE;
        end
        sdl_pkg::CMD_CHANGE: begin
          if (en && !busy && (lvl != active)) begin
            active_next = lvl;
            phase_next  = sdl_pkg::PH_DEGLITCH;
            cnt_next    = cnt_start;
          end
        end
        sdl_pkg::CMD_TICK: begin
          if (en && busy) begin
            cnt_next = cnt_inc;
            if (hit_lockout) begin
              phase_next = sdl_pkg::PH_IDLE;
              // re-check the pin on return to idle
              if (lvl != active) begin
                active_next = lvl;
                phase_next  = sdl_pkg::PH_DEGLITCH;
                cnt_next    = cnt_start;
              end
            end else if (hit_zero) begin
              phase_next = sdl_pkg::PH_LOCKOUT;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    stat.active = active_next;
    stat.fired  = ctrl.step && (ctrl.cmd == sdl_pkg::CMD_TICK) && en && busy &&
                  !hit_lockout && hit_zero;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= sdl_pkg::PH_IDLE;
      cnt    <= '0;
      active <= 1'b0;
    end else begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      active <= active_next;
    end
  end

  // A firing switch sits in lockout with a zero count
  a_fire_lockout: assert property (@(posedge clk) disable iff (rst)
    stat.fired |=> (phase == sdl_pkg::PH_LOCKOUT) && (cnt == '0))
    else $error("fired switch did not enter lockout");

  // Resync always leaves the switch idle
  a_resync_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && (ctrl.cmd == sdl_pkg::CMD_RESYNC)) |=> (phase == sdl_pkg::PH_IDLE))
    else $error("resync left switch busy");

  // A disabled switch is frozen outside resync
  a_disabled_frozen: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && !en && (ctrl.cmd != sdl_pkg::CMD_RESYNC))
      |=> ($stable(cnt) && $stable(active) && $stable(phase)))
    else $error("disabled switch changed state");

endmodule

// File: hw/rtl/switch_deglitch_lockout.sv
// ----------------------------------------------------------------------------
// switch_deglitch_lockout
// Deglitch and lockout qualifier for limit and e-stop switch inputs.
// ----------------------------------------------------------------------------
// Takes one item per clock with no gaps while the output is ready: each item
// goes into an input register, every switch lane updates in parallel from it,
// and the result lands in an output register. The per-switch update (one 16-bit
// increment and two compares) between those two registers sets the rate. A
// stalled result holds the item in the input register, and no further item is
// taken until the result is taken. Write the switch types, deglitch and lockout
// ticks while idle, then send a resync.
module switch_deglitch_lockout (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [sdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdl_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sdl_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // cmd, pin_levels, zero pad
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sdl_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // active_mask, fired_mask, zero pad
);

  logic [sdl_pkg::TYPES_W-1:0]      switch_types;
  logic [sdl_pkg::TICKS_W-1:0]      deglitch_ticks;
  logic [sdl_pkg::TICKS_W-1:0]      lockout_ticks;
  logic                             in_valid;
  logic [sdl_pkg::CMD_W-1:0]        in_cmd;
  logic [sdl_pkg::NUM_SWITCHES-1:0] in_pins;
  logic                             advance;
  logic                             out_valid;
  logic [sdl_pkg::NUM_SWITCHES-1:0] out_active;
  logic [sdl_pkg::NUM_SWITCHES-1:0] out_fired;
  logic [sdl_pkg::NUM_SWITCHES-1:0] lane_active;
  logic [sdl_pkg::NUM_SWITCHES-1:0] lane_fired;
  sdl_pkg::sdl_ctrl_t               ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_types   <= sdl_pkg::SWITCH_TYPES_RST;
      deglitch_ticks <= sdl_pkg::DEGLITCH_TICKS_RST;
      lockout_ticks  <= sdl_pkg::LOCKOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdl_pkg::REG_SWITCH_TYPES:   switch_types   <= cfg_data;
        sdl_pkg::REG_DEGLITCH_TICKS: deglitch_ticks <= cfg_data[sdl_pkg::TICKS_W-1:0];
        sdl_pkg::REG_LOCKOUT_TICKS:  lockout_ticks  <= cfg_data[sdl_pkg::TICKS_W-1:0];
        default: begin
          switch_types <= switch_types;
        end
      endcase
    end
  end

  // Advance when the input register holds an item and the output slot is free or being taken
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tdata[sdl_pkg::CMD_W-1:0];
      in_pins <= s_axis_tdata[sdl_pkg::CMD_W +: sdl_pkg::NUM_SWITCHES];
    end
  end

  // Shared lane control
  always_comb begin
    ctrl.step           = advance;
    ctrl.cmd            = in_cmd;
    ctrl.deglitch_ticks = deglitch_ticks;
    ctrl.lockout_ticks  = lockout_ticks;
  end

  // Switch lanes
  for (genvar i = 0; i < sdl_pkg::NUM_SWITCHES; i++) begin : g_lane
    sdl_pkg::sdl_stat_t stat;

    sdl_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sw_type (switch_types[sdl_pkg::TYPE_W*i +: sdl_pkg::TYPE_W]),
      .pin     (in_pins[i]),
      .stat    (stat)
    );

    assign lane_active[i] = stat.active;
    assign lane_fired[i]  = stat.fired;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_active <= lane_active;
      out_fired  <= lane_fired;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(sdl_pkg::OUT_DATA_W - sdl_pkg::OUT_BITS)'(0), out_fired, out_active};

endmodule
